/* design/fskid_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and codes of the FSK interval demodulator and deframer.
package fskid_pkg;

    localparam int TIME_W     = 16;
    localparam int THR_W      = 16;
    localparam int PERIOD_W   = 16;
    localparam int CHUNK_W    = 6;
    localparam int SUM_W      = 24;
    localparam int MAX_BITS   = 64;
    localparam int FRAME_LEN  = 11;
    localparam int BYTE_W     = 8;
    localparam int LIM_W      = PERIOD_W + CHUNK_W;
    localparam int CNT_W      = $clog2(MAX_BITS + 1);
    localparam int POS_W      = $clog2(FRAME_LEN);
    localparam int DIV_STEP_W = $clog2(SUM_W + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0]    RST_LOW_THR  = 16'd910;
    localparam logic [THR_W-1:0]    RST_HIGH_THR = 16'd1102;
    localparam logic [PERIOD_W-1:0] RST_PERIOD   = 16'd2600;
    localparam logic [CHUNK_W-1:0]  RST_CHUNK    = 6'd11;

    typedef struct packed {
        logic [THR_W-1:0]    low_thr;
        logic [THR_W-1:0]    high_thr;
        logic [PERIOD_W-1:0] period;
        logic [CHUNK_W-1:0]  chunk;
    } t_cfg;

    // Request to the emitter: send count copies of value.
    typedef struct packed {
        logic             load;
        logic             value;
        logic [CNT_W-1:0] count;
    } t_emit_load;

    // Request to the rounding divider.
    typedef struct packed {
        logic                start;
        logic [SUM_W-1:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } t_div_rsp;

endpackage

/* design/fskid_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for capture times and demodulated bits.
interface fskid_in_if;
    logic                         valid;
    logic                         ready;
    logic [fskid_pkg::TIME_W-1:0] capture_time;

    modport source (output valid, output capture_time, input ready);
    modport sink (input valid, input capture_time, output ready);
endinterface

interface fskid_out_if;
    logic                         valid;
    logic                         ready;
    logic                         bit_value;
    logic                         byte_ready;
    logic [fskid_pkg::BYTE_W-1:0] data_byte;
    logic                         last;

    modport source (output valid, output bit_value, output byte_ready, output data_byte,
                    output last, input ready);
    modport sink (input valid, input bit_value, input byte_ready, input data_byte,
                  input last, output ready);
endinterface

/* design/fskid_divider.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider that gives the rounded, saturated bit count of a run.
module fskid_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fskid_pkg::t_div_req i_req,
    output fskid_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic                                r_fin;
    logic [fskid_pkg::DIV_STEP_W-1:0]    r_step;
    logic [fskid_pkg::SUM_W-1:0]         r_quo;
    logic [fskid_pkg::PERIOD_W-1:0]      r_rem;
    logic [fskid_pkg::PERIOD_W-1:0]      r_div;
    logic                                r_done;
    logic [fskid_pkg::CNT_W-1:0]         r_count;

    logic [fskid_pkg::PERIOD_W:0]        trial;
    logic                                fits;
    logic [fskid_pkg::PERIOD_W:0]        twice_rem;
    logic                                round_up;
    logic [fskid_pkg::SUM_W:0]           q_round;

    // One quotient bit per cycle; the partial remainder stays below the divisor.
    assign trial     = {r_rem, r_quo[fskid_pkg::SUM_W-1]};
    assign fits      = trial >= {1'b0, r_div};
    assign twice_rem = {r_rem, 1'b0};
    assign round_up  = twice_rem >= {1'b0, r_div};
    assign q_round   = {1'b0, r_quo} + {{fskid_pkg::SUM_W{1'b0}}, round_up};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= fskid_pkg::DIV_STEP_W'(fskid_pkg::SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == fskid_pkg::DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[fskid_pkg::SUM_W-2:0], fits};
            if (fits) begin
                r_rem <= fskid_pkg::PERIOD_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[fskid_pkg::PERIOD_W-1:0];
            end
        end
        if (r_fin) begin
            if (q_round > (fskid_pkg::SUM_W + 1)'(fskid_pkg::MAX_BITS)) begin
                r_count <= fskid_pkg::CNT_W'(fskid_pkg::MAX_BITS);
            end else begin
                r_count <= q_round[fskid_pkg::CNT_W-1:0];
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.count = r_count;

endmodule

/* design/fskid_emitter.sv */
`timescale 1ns / 1ps
// Serial bit emitter with the UART frame deframer and the output register.
module fskid_emitter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fskid_pkg::t_emit_load i_load,
    output logic                  o_busy,
    fskid_out_if.source           o_out
);

    logic [fskid_pkg::CNT_W-1:0]       r_remaining;
    logic                              r_value;
    logic [fskid_pkg::POS_W-1:0]       r_pos;
    logic [fskid_pkg::FRAME_LEN-2:0]   r_shift;
    logic                              r_valid;
    logic                              r_bit;
    logic                              r_byte_ready;
    logic [fskid_pkg::BYTE_W-1:0]      r_byte;
    logic                              r_last;

    logic                              step;
    logic [fskid_pkg::POS_W-1:0]       n_pos;
    logic [fskid_pkg::FRAME_LEN-2:0]   n_shift;
    logic                              frame_done;

    assign step = (r_remaining != '0) && (!r_valid || o_out.ready);

    always_comb begin
        n_pos      = r_pos;
        n_shift    = r_shift;
        frame_done = 1'b0;
        if (r_pos == '0) begin
            if (!r_value) begin
                n_shift = '0;
                n_pos   = fskid_pkg::POS_W'(1);
            end
        end else begin
            n_shift = {r_value, r_shift[fskid_pkg::FRAME_LEN-2:1]};
            if (r_pos == fskid_pkg::POS_W'(fskid_pkg::FRAME_LEN - 1)) begin
                n_pos      = '0;
                frame_done = 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_pos       <= '0;
            r_shift     <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_load.load) begin
                r_remaining <= i_load.count;
            end else if (step) begin
                r_remaining <= r_remaining - 1'b1;
            end
            if (step) begin
                r_pos   <= n_pos;
                r_shift <= n_shift;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_value <= i_load.value;
        end
        if (step) begin
            r_bit        <= r_value;
            r_byte_ready <= frame_done;
            r_byte       <= frame_done ? n_shift[fskid_pkg::BYTE_W-1:0] : '0;
            r_last       <= r_remaining == fskid_pkg::CNT_W'(1);
        end
    end

    assign o_busy           = r_remaining != '0;
    assign o_out.valid      = r_valid;
    assign o_out.bit_value  = r_bit;
    assign o_out.byte_ready = r_byte_ready;
    assign o_out.data_byte  = r_byte;
    assign o_out.last       = r_last;

endmodule

/* design/fskid_demod.sv */
`timescale 1ns / 1ps
// Interval classifier and run accumulator that decides how many bits each edge releases.
module fskid_demod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [fskid_pkg::TIME_W-1:0]  i_capture_time,
    input  fskid_pkg::t_cfg               i_cfg,
    input  logic [fskid_pkg::LIM_W-1:0]   i_chunk_lim,
    input  logic                          i_emit_busy,
    input  fskid_pkg::t_div_rsp           i_div_rsp,
    output logic                          o_idle,
    output fskid_pkg::t_div_req           o_div_req,
    output fskid_pkg::t_emit_load         o_emit
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CLASS = 3'b010,
        ST_DIV   = 3'b100
    } t_state;

    typedef enum logic [2:0] {
        PH_FIRST = 3'b001,
        PH_SPACE = 3'b010,
        PH_MARK  = 3'b100
    } t_phase;

    t_state                          r_state, n_state;
    t_phase                          r_phase, n_phase;
    logic [fskid_pkg::TIME_W-1:0]    r_prev;
    logic [fskid_pkg::TIME_W-1:0]    r_d;
    logic [fskid_pkg::SUM_W-1:0]     r_sum, n_sum;
    logic                            r_flank, n_flank;

    logic                            gt_hi, lt_lo, lt_hi, decisive;
    logic [fskid_pkg::SUM_W:0]       sum_wide;
    logic [fskid_pkg::SUM_W-1:0]     sum_d;
    logic [fskid_pkg::SUM_W-1:0]     d_ext;

    assign gt_hi    = r_d > i_cfg.high_thr;
    assign lt_lo    = r_d < i_cfg.low_thr;
    assign lt_hi    = r_d < i_cfg.high_thr;
    assign d_ext    = fskid_pkg::SUM_W'(r_d);
    assign sum_wide = {1'b0, r_sum} + {1'b0, d_ext};
    assign sum_d    = sum_wide[fskid_pkg::SUM_W] ? '1 : sum_wide[fskid_pkg::SUM_W-1:0];
    assign decisive = (r_phase == PH_MARK) ? lt_lo : gt_hi;

    always_comb begin
        n_state            = r_state;
        n_phase            = r_phase;
        n_sum              = r_sum;
        n_flank            = r_flank;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_sum;
        o_div_req.divisor  = i_cfg.period;
        o_emit.load        = 1'b0;
        o_emit.value       = 1'b1;
        o_emit.count       = fskid_pkg::CNT_W'(i_cfg.chunk);
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = ST_CLASS;
                end
            end
            ST_CLASS: begin
                n_state = ST_IDLE;
                if ((r_phase == PH_MARK && gt_hi) ||
                    (r_phase == PH_SPACE && lt_lo && !gt_hi)) begin
                    // The run goes on; a long mark run flushes whole idle chunks.
                    n_sum = sum_d;
                    if (r_phase == PH_MARK && sum_d >= fskid_pkg::SUM_W'(i_chunk_lim)) begin
                        n_sum       = '0;
                        o_emit.load = 1'b1;
                    end
                end else if (r_phase == PH_MARK || r_phase == PH_SPACE) begin
                    // The run ends; a flank joins it once and always seeds the next run.
                    o_div_req.dividend = (!decisive && !r_flank) ? sum_d : r_sum;
                    n_flank            = !decisive;
                    n_sum              = d_ext;
                    n_phase            = (r_phase == PH_MARK) ? PH_SPACE : PH_MARK;
                    if (i_cfg.period != '0) begin
                        o_div_req.start = 1'b1;
                        n_state         = ST_DIV;
                    end
                end else begin
                    if (gt_hi) begin
                        n_phase = PH_MARK;
                        n_sum   = d_ext;
                    end else if (lt_hi) begin
                        n_phase = PH_SPACE;
                        n_sum   = d_ext;
                    end
                end
            end
            ST_DIV: begin
                o_emit.value = r_phase != PH_MARK;
                o_emit.count = i_div_rsp.count;
                if (i_div_rsp.done) begin
                    o_emit.load = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_FIRST;
            r_prev  <= '0;
            r_sum   <= '0;
            r_flank <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_flank <= n_flank;
            if (i_accept) begin
                r_prev <= i_capture_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_d <= i_capture_time - r_prev;
        end
    end

    assign o_idle = (r_state == ST_IDLE) && !i_emit_busy;

endmodule

/* design/fsk_interval_demod_uart_deframer_core.sv */
`timescale 1ns / 1ps
// Top level of the FSK interval demodulator with UART deframer.
//
// Usage: i_in carries one transaction per captured signal edge (a 16-bit timer value).
// The block forms the interval since the previous capture, classes it as a mark, a
// space or a transition flank, and sums like half-periods into a run. When a run ends,
// a bit-serial divider rounds the run length to a bit count (at most 64); a long mark
// run releases idle_chunk ones at once. Each bit leaves on o_out as one transaction,
// together with the byte of a completed 11-bit UART frame and a flag on the last bit
// that the edge released.
// Timing: each accepted edge is classified; one that ends a run then goes through the
// divider when the period is not zero, and its bits leave one per cycle while o_out
// takes them. The next edge is taken once the last bit of the previous one sits in the
// output register.
// Configuration writes are registered; write only while the block is idle.
// Reset (synchronous, active low) restores the register defaults, clears the run, the
// phase and the deframer, and empties the output register.
// A stall on o_out holds the current bit in the output register and pauses the
// emitter and the deframer; no bit is lost or repeated.
module fsk_interval_demod_uart_deframer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fskid_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fskid_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fskid_in_if.sink                          i_in,
    fskid_out_if.source                       o_out
);

    fskid_pkg::t_cfg                  r_cfg;
    logic [fskid_pkg::LIM_W-1:0]      r_chunk_lim;
    logic                             idle;
    logic                             accept;
    logic                             emit_busy;
    fskid_pkg::t_div_req              div_req;
    fskid_pkg::t_div_rsp              div_rsp;
    fskid_pkg::t_emit_load            emit_load;

    // Configuration registers; all four indexes are defined.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_thr  <= fskid_pkg::RST_LOW_THR;
            r_cfg.high_thr <= fskid_pkg::RST_HIGH_THR;
            r_cfg.period   <= fskid_pkg::RST_PERIOD;
            r_cfg.chunk    <= fskid_pkg::RST_CHUNK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fskid_pkg::CFG_LOW_THR:  r_cfg.low_thr  <= i_cfg_data;
                fskid_pkg::CFG_HIGH_THR: r_cfg.high_thr <= i_cfg_data;
                fskid_pkg::CFG_PERIOD:   r_cfg.period   <= i_cfg_data;
                fskid_pkg::CFG_CHUNK:
                    r_cfg.chunk <= i_cfg_data[fskid_pkg::CHUNK_W-1:0];
                default: ;
            endcase
        end
    end

    // The idle-chunk limit in timer ticks, recomputed every cycle from the registers.
    // It is updated in the cycle after a write reaches the configuration registers.
    always_ff @(posedge i_clk) begin
        r_chunk_lim <= fskid_pkg::LIM_W'(r_cfg.period * r_cfg.chunk);
    end

    assign i_in.ready = idle;
    assign accept     = i_in.valid && idle;

    fskid_demod u_demod (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_capture_time (i_in.capture_time),
        .i_cfg          (r_cfg),
        .i_chunk_lim    (r_chunk_lim),
        .i_emit_busy    (emit_busy),
        .i_div_rsp      (div_rsp),
        .o_idle         (idle),
        .o_div_req      (div_req),
        .o_emit         (emit_load)
    );

    fskid_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fskid_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit_load),
        .o_busy  (emit_busy),
        .o_out   (o_out)
    );

endmodule
